// ----- rtl/assert_macros.svh -----
// Assertion macros used by the decoder datapath.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_AT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/pcxrle_pkg.sv -----
// Package for the PCX RLE plane decoder: widths, codes and the
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package pcxrle_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned LINE_W     = 13;
  localparam int unsigned ROWS_W     = 13;
  localparam int unsigned PAD_W      = 8;
  localparam int unsigned PLANES_W   = 3;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [BYTE_W-1:0]   RUN_MARK   = 8'hc0;
  localparam logic [BYTE_W-1:0]   COUNT_MASK = 8'h3f;
  localparam logic [PLANES_W-1:0] MAX_PLANES = 3'd4;

  typedef enum logic [1:0] {
    LAYOUT_MONO        = 2'd0,
    LAYOUT_PLANAR      = 2'd1,
    LAYOUT_INTERLEAVED = 2'd2
  } layout_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYOUT_MODE = 3'd0,
    REG_LINE_BYTES  = 3'd1,
    REG_PAD_BYTES   = 3'd2,
    REG_PLANE_COUNT = 3'd3,
    REG_ROW_COUNT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic accept;
    logic calc;
    logic pad_step;
    logic emit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic start_work;
    logic finished;
    logic produce;
    logic done;
    logic cnt_last;
    logic adv_finish;
    logic hold_valid;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/pcx_rle_plane_decoder.sv -----
// Top level of the PCX RLE plane decoder.
// Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_dpath.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid_i/in_stall_o/data_byte_i carries one compressed byte
//   per request. Output channel out_valid_o/out_stall_i carries decoded bytes
//   with their destination address, run_end_o on the last byte of a request and
//   image_done_o on the byte that completes the final row.
//   Configuration: write cfg_data_i to register cfg_index_i (0 layout, 1 line
//   bytes, 2 pad bytes, 3 plane count, 4 row count) while cfg_we_i is high.
//   Sequencing: a run header is taken in the idle state alone. Each kept byte
//   passes a line position multiply, then an address select; each pad byte is
//   a single skip step. A literal or run adds an accept step before its bytes
//   and a flush step that releases its last byte to the output register.
//   in_stall_o stays high while a request is being expanded.
//   A stalled receiver holds the output register; the next byte waits in a
//   hold stage and the sequencer pauses until the output frees.
//   Reset clears the position to row 0, plane 0, column 0 and restores the
//   register defaults. After the final row all further requests are taken and
//   dropped until reset.
module pcx_rle_plane_decoder #(
  parameter int unsigned MAX_LINE_BYTES = 4096,
  parameter int unsigned MAX_ROWS       = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pcxrle_pkg::BYTE_W-1:0]         data_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [pcxrle_pkg::BYTE_W-1:0]         pixel_byte_o,
  output logic [pcxrle_pkg::ADDR_W-1:0]         dest_address_o,
  output logic                                  run_end_o,
  output logic                                  image_done_o
);

  pcxrle_pkg::cmd_t    cmd;
  pcxrle_pkg::status_t status;

  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pcxrle_dpath #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_ROWS       (MAX_ROWS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .pixel_byte_o   (pixel_byte_o),
    .dest_address_o (dest_address_o),
    .run_end_o      (run_end_o),
    .image_done_o   (image_done_o)
  );

endmodule

// ----- rtl/pcxrle_ctrl.sv -----
// Controller of the PCX RLE plane decoder: request intake and per-byte sequencing.
// Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pcxrle_pkg::status_t status_i,
  output logic                in_stall_o,
  output pcxrle_pkg::cmd_t    cmd_o
);

  pcxrle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcxrle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pcxrle_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.start_work) begin
            state_d = pcxrle_pkg::ST_CALC;
          end
        end
      end
      pcxrle_pkg::ST_CALC: begin
        if (status_i.finished) begin
          state_d = pcxrle_pkg::ST_FLUSH;
        end else if (status_i.produce) begin
          cmd_o.calc = 1'b1;
          state_d    = pcxrle_pkg::ST_ADDR;
        end else begin
          cmd_o.pad_step = 1'b1;
          if (status_i.cnt_last || status_i.adv_finish) begin
            state_d = pcxrle_pkg::ST_FLUSH;
          end
        end
      end
      pcxrle_pkg::ST_ADDR: begin
        if (!status_i.hold_valid || status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.done || status_i.cnt_last || status_i.adv_finish) begin
            state_d = pcxrle_pkg::ST_FLUSH;
          end else begin
            state_d = pcxrle_pkg::ST_CALC;
          end
        end
      end
      pcxrle_pkg::ST_FLUSH: begin
        if (!status_i.hold_valid) begin
          state_d = pcxrle_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = pcxrle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcxrle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pcxrle_dpath.sv -----
// Datapath of the PCX RLE plane decoder: configuration, run and position state,
// address arithmetic, hold stage and output register. Depends on pcxrle_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcxrle_dpath #(
  parameter int unsigned MAX_LINE_BYTES = 4096,
  parameter int unsigned MAX_ROWS       = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [pcxrle_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic                                  out_stall_i,
  input  pcxrle_pkg::cmd_t                      cmd_i,
  output pcxrle_pkg::status_t                   status_o,
  output logic                                  out_valid_o,
  output logic [pcxrle_pkg::BYTE_W-1:0]         pixel_byte_o,
  output logic [pcxrle_pkg::ADDR_W-1:0]         dest_address_o,
  output logic                                  run_end_o,
  output logic                                  image_done_o
);

  localparam int unsigned AW    = pcxrle_pkg::ADDR_W;
  localparam int unsigned LW    = pcxrle_pkg::LINE_W;
  localparam int unsigned RCW   = pcxrle_pkg::ROWS_W;
  localparam int unsigned PCW   = pcxrle_pkg::PLANES_W;
  localparam int unsigned PW    = pcxrle_pkg::PLANE_W;
  localparam int unsigned BW    = pcxrle_pkg::BYTE_W;
  localparam int unsigned RW    = pcxrle_pkg::RUN_W;
  localparam int unsigned COL_W = $clog2(MAX_LINE_BYTES + 257);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS + 1);

  function automatic logic [AW-1:0] mul_small(input logic [AW-1:0] a,
                                              input logic [PCW-1:0] k);
    logic [AW-1:0] p0, p1, p2;
    p0 = k[0] ? a : '0;
    p1 = k[1] ? (a << 1) : '0;
    p2 = k[2] ? (a << 2) : '0;
    return p0 + p1 + p2;
  endfunction

  // configuration
  logic [1:0]                     layout_q;
  logic [LW-1:0]                  line_bytes_q;
  logic [pcxrle_pkg::PAD_W-1:0]   pad_bytes_q;
  logic [PCW-1:0]                 plane_count_q;
  logic [RCW-1:0]                 row_count_q;

  // run and position state
  logic             await_q, await_d;
  logic [RW-1:0]    run_length_q, run_length_d;
  logic [RW-1:0]    cnt_q, cnt_d;
  logic             finished_q, finished_d;
  logic [COL_W-1:0] column_q, column_d;
  logic [PW-1:0]    plane_q, plane_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             hold_valid_q, hold_valid_d;
  logic             out_valid_q, out_valid_d;

  // payload
  logic [BW-1:0] value_q;
  logic [AW-1:0] line_pos_q;
  logic [AW-1:0] lr_q;
  logic [BW-1:0] hold_pixel_q;
  logic [AW-1:0] hold_addr_q;
  logic          hold_done_q;
  logic [BW-1:0] out_pixel_q;
  logic [AW-1:0] out_addr_q;
  logic          out_run_end_q;
  logic          out_done_q;

  logic [LW-1:0]  lb;
  logic [RCW-1:0] rows;
  logic [PCW-1:0] pc;
  logic [LW:0]    span;
  logic           is_header;
  logic           produce, col_wrap, plane_wrap, row_last, done, adv_finish;
  logic           out_free, move_hold, move_last;
  logic [COL_W-1:0] column_adv;
  logic [PW-1:0]    plane_adv;
  logic [ROW_W-1:0] row_adv;
  logic [BW-1:0]    cand_pixel;
  logic [AW-1:0]    cand_addr;

  always_comb begin
    if (line_bytes_q == '0) begin
      lb = LW'(1);
    end else if (32'(line_bytes_q) > 32'(MAX_LINE_BYTES)) begin
      lb = LW'(MAX_LINE_BYTES);
    end else begin
      lb = line_bytes_q;
    end
    if (row_count_q == '0) begin
      rows = RCW'(1);
    end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = row_count_q;
    end
    if (layout_q == pcxrle_pkg::LAYOUT_MONO || plane_count_q == '0) begin
      pc = PCW'(1);
    end else if (plane_count_q > pcxrle_pkg::MAX_PLANES) begin
      pc = pcxrle_pkg::MAX_PLANES;
    end else begin
      pc = plane_count_q;
    end
  end

  assign span       = {1'b0, lb} + (LW + 1)'(pad_bytes_q);
  assign is_header  = (data_byte_i & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
  assign produce    = 32'(column_q) < 32'(lb);
  assign col_wrap   = (32'(column_q) + 32'd1) >= 32'(span);
  assign plane_wrap = ({1'b0, plane_q} + PCW'(1)) >= pc;
  assign row_last   = (32'(row_q) + 32'd1) >= 32'(rows);
  assign done       = ((32'(column_q) + 32'd1) == 32'(lb)) && plane_wrap && row_last;
  assign adv_finish = col_wrap && plane_wrap && row_last;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign column_adv = col_wrap ? '0 : column_q + 1'b1;
  assign plane_adv  = col_wrap ? (plane_wrap ? '0 : plane_q + 1'b1) : plane_q;
  assign row_adv    = (col_wrap && plane_wrap) ? row_q + 1'b1 : row_q;

  assign cand_pixel = (layout_q == pcxrle_pkg::LAYOUT_MONO) ? ~value_q : value_q;

  always_comb begin
    case (layout_q)
      pcxrle_pkg::LAYOUT_MONO:   cand_addr = line_pos_q;
      pcxrle_pkg::LAYOUT_PLANAR: cand_addr = mul_small(lr_q, {1'b0, plane_q}) + line_pos_q;
      default:                   cand_addr = mul_small(line_pos_q, pc) + AW'(plane_q);
    endcase
  end

  always_comb begin
    await_d      = await_q;
    run_length_d = run_length_q;
    cnt_d        = cnt_q;
    finished_d   = finished_q;
    column_d     = column_q;
    plane_d      = plane_q;
    row_d        = row_q;
    hold_valid_d = hold_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    move_hold    = 1'b0;
    move_last    = 1'b0;
    if (cmd_i.accept && !finished_q) begin
      if (await_q) begin
        await_d      = 1'b0;
        run_length_d = '0;
        cnt_d        = run_length_q;
      end else if (is_header) begin
        run_length_d = RW'(data_byte_i & pcxrle_pkg::COUNT_MASK);
        await_d      = 1'b1;
      end else begin
        cnt_d = RW'(1);
      end
    end
    if (cmd_i.pad_step) begin
      cnt_d    = cnt_q - 1'b1;
      column_d = column_adv;
      plane_d  = plane_adv;
      row_d    = row_adv;
      if (adv_finish) begin
        finished_d = 1'b1;
      end
    end
    if (cmd_i.emit) begin
      cnt_d        = cnt_q - 1'b1;
      hold_valid_d = 1'b1;
      move_hold    = hold_valid_q;
      if (done) begin
        finished_d = 1'b1;
      end else begin
        column_d = column_adv;
        plane_d  = plane_adv;
        row_d    = row_adv;
        if (adv_finish) begin
          finished_d = 1'b1;
        end
      end
    end
    if (cmd_i.flush) begin
      hold_valid_d = 1'b0;
      move_hold    = 1'b1;
      move_last    = 1'b1;
    end
    if (move_hold) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q      <= pcxrle_pkg::LAYOUT_MONO;
      line_bytes_q  <= LW'(1);
      pad_bytes_q   <= '0;
      plane_count_q <= PCW'(1);
      row_count_q   <= RCW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pcxrle_pkg::REG_LAYOUT_MODE: layout_q      <= cfg_data_i[1:0];
        pcxrle_pkg::REG_LINE_BYTES:  line_bytes_q  <= cfg_data_i[LW-1:0];
        pcxrle_pkg::REG_PAD_BYTES:   pad_bytes_q   <= cfg_data_i[pcxrle_pkg::PAD_W-1:0];
        pcxrle_pkg::REG_PLANE_COUNT: plane_count_q <= cfg_data_i[PCW-1:0];
        pcxrle_pkg::REG_ROW_COUNT:   row_count_q   <= cfg_data_i[RCW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q      <= 1'b0;
      run_length_q <= '0;
      cnt_q        <= '0;
      finished_q   <= 1'b0;
      column_q     <= '0;
      plane_q      <= '0;
      row_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      await_q      <= await_d;
      run_length_q <= run_length_d;
      cnt_q        <= cnt_d;
      finished_q   <= finished_d;
      column_q     <= column_d;
      plane_q      <= plane_d;
      row_q        <= row_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q <= AW'(AW'(lb) * AW'(rows));
    if (cmd_i.accept) begin
      value_q <= data_byte_i;
    end
    if (cmd_i.calc) begin
      line_pos_q <= AW'(AW'(row_q) * AW'(lb)) + AW'(column_q);
    end
    if (cmd_i.emit) begin
      hold_pixel_q <= cand_pixel;
      hold_addr_q  <= cand_addr;
      hold_done_q  <= done;
    end
    if (move_hold) begin
      out_pixel_q   <= hold_pixel_q;
      out_addr_q    <= hold_addr_q;
      out_done_q    <= hold_done_q;
      out_run_end_q <= move_last;
    end
  end

  always_comb begin
    status_o.start_work = !finished_q && (await_q ? (run_length_q != '0) : !is_header);
    status_o.finished   = finished_q;
    status_o.produce    = produce;
    status_o.done       = done;
    status_o.cnt_last   = cnt_q == RW'(1);
    status_o.adv_finish = adv_finish;
    status_o.hold_valid = hold_valid_q;
    status_o.out_free   = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_byte_o   = out_pixel_q;
  assign dest_address_o = out_addr_q;
  assign run_end_o      = out_run_end_q;
  assign image_done_o   = out_done_q;

  `ASSERT_IMPLIES(a_no_overwrite, cmd_i.emit && hold_valid_q, out_free,
                  "hold moved into a busy output register")
  `ASSERT_IMPLIES(a_idle_after_done, finished_q, !cmd_i.emit && !cmd_i.calc,
                  "byte produced after the image completed")
  `ASSERT_IMPLIES(a_done_ends_run, out_valid_q && out_done_q, out_run_end_q,
                  "image completion not marked as end of run")
  `ASSERT_IMPLIES(a_count_live, cmd_i.emit || cmd_i.pad_step, cnt_q != '0,
                  "run step with an exhausted count")

endmodule

// ----- tb/pcx_rle_plane_decoder_tb.sv -----
// Testbench for pcx_rle_plane_decoder. It streams compressed bytes, predicts each decoded
// pixel with its address and flags, and checks the output stream in order.
// Depends on pcxrle_pkg and the decoder RTL.
`timescale 1ns / 1ps

module pcx_rle_plane_decoder_tb;

  localparam int unsigned LINE_LIMIT    = 4096;
  localparam int unsigned ROW_LIMIT     = 4096;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_BYTES   = 28;

  typedef struct {
    logic [pcxrle_pkg::BYTE_W-1:0] pixel;
    logic [pcxrle_pkg::ADDR_W-1:0] addr;
    logic                          run_end;
    logic                          image_done;
  } pixel_t;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [pcxrle_pkg::CFG_IDX_W-1:0]  cfg_index_i = pcxrle_pkg::REG_LAYOUT_MODE;
  logic [pcxrle_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic [pcxrle_pkg::BYTE_W-1:0]     data_byte_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [pcxrle_pkg::BYTE_W-1:0]     pixel_byte_o;
  logic [pcxrle_pkg::ADDR_W-1:0]     dest_address_o;
  logic                              run_end_o;
  logic                              image_done_o;

  // Decoder image: configuration and stream position.
  logic [1:0]  cfg_layout = pcxrle_pkg::LAYOUT_MONO;
  int unsigned cfg_line   = 1;
  int unsigned cfg_pad    = 0;
  int unsigned cfg_planes = 1;
  int unsigned cfg_rows   = 1;
  bit          pend_run     = 1'b0;
  int unsigned run_left     = 0;
  int unsigned col          = 0;
  int unsigned plane_idx    = 0;
  int unsigned row_idx      = 0;
  bit          img_finished = 1'b0;

  pixel_t                        expected_pixels[$];
  logic [pcxrle_pkg::BYTE_W-1:0] pending_bytes[$];
  pixel_t                        head_px;
  bit                            idle_on        = 1'b1;
  int unsigned                   in_gap         = 0;
  int unsigned                   stall_left     = 0;
  int unsigned                   mismatches     = 0;
  int unsigned                   pixels_checked = 0;
  int unsigned                   bytes_taken    = 0;

  pcx_rle_plane_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_byte_o  (pixel_byte_o),
    .dest_address_o(dest_address_o),
    .run_end_o     (run_end_o),
    .image_done_o  (image_done_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Place one byte at the current position, then advance the position.
  function automatic void emit_pixel(input logic [pcxrle_pkg::BYTE_W-1:0] value);
    int unsigned lb, rows, pc, span, line_pos, addr;
    pixel_t px;
    if (img_finished) return;
    lb   = clip(cfg_line, 1, LINE_LIMIT);
    rows = clip(cfg_rows, 1, ROW_LIMIT);
    pc   = (cfg_layout == pcxrle_pkg::LAYOUT_MONO) ? 1 :
           clip(cfg_planes, 1, pcxrle_pkg::MAX_PLANES);
    span = lb + cfg_pad;
    if (col < lb) begin
      line_pos = row_idx * lb + col;
      if (cfg_layout == pcxrle_pkg::LAYOUT_MONO) addr = line_pos;
      else if (cfg_layout == pcxrle_pkg::LAYOUT_PLANAR) addr = plane_idx * lb * rows + line_pos;
      else addr = line_pos * pc + plane_idx;
      px.pixel      = (cfg_layout == pcxrle_pkg::LAYOUT_MONO) ? ~value : value;
      px.addr       = addr[pcxrle_pkg::ADDR_W-1:0];
      px.run_end    = 1'b0;
      px.image_done = (col == lb - 1) && (plane_idx + 1 >= pc) && (row_idx + 1 >= rows);
      expected_pixels.push_back(px);
      if (px.image_done) begin
        img_finished = 1'b1;
        return;
      end
    end
    col++;
    if (col >= span) begin
      col = 0;
      plane_idx++;
      if (plane_idx >= pc) begin
        plane_idx = 0;
        row_idx++;
        if (row_idx >= rows) img_finished = 1'b1;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [pcxrle_pkg::BYTE_W-1:0] b);
    int unsigned queued = expected_pixels.size();
    if (img_finished) return;
    if (pend_run) begin
      pend_run = 1'b0;
      repeat (run_left) emit_pixel(b);
      run_left = 0;
    end else if ((b & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK) begin
      run_left = b & pcxrle_pkg::COUNT_MASK;
      pend_run = 1'b1;
    end else begin
      emit_pixel(b);
    end
    if (expected_pixels.size() > queued)
      expected_pixels[expected_pixels.size() - 1].run_end = 1'b1;
  endfunction

  task automatic write_reg(input pcxrle_pkg::cfg_reg_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[pcxrle_pkg::CFG_DATA_W-1:0];
    case (idx)
      pcxrle_pkg::REG_LAYOUT_MODE: cfg_layout = val[1:0];
      pcxrle_pkg::REG_LINE_BYTES:  cfg_line   = val & 32'h1fff;
      pcxrle_pkg::REG_PAD_BYTES:   cfg_pad    = val & 32'hff;
      pcxrle_pkg::REG_PLANE_COUNT: cfg_planes = val & 32'h7;
      pcxrle_pkg::REG_ROW_COUNT:   cfg_rows   = val & 32'h1fff;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned mode_v, input int unsigned line_v,
                           input int unsigned pad_v, input int unsigned planes_v,
                           input int unsigned rows_v);
    write_reg(pcxrle_pkg::REG_LAYOUT_MODE, mode_v);
    write_reg(pcxrle_pkg::REG_LINE_BYTES, line_v);
    write_reg(pcxrle_pkg::REG_PAD_BYTES, pad_v);
    write_reg(pcxrle_pkg::REG_PLANE_COUNT, planes_v);
    write_reg(pcxrle_pkg::REG_ROW_COUNT, rows_v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every request is taken and every pixel is back, then let pads drain.
  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly run pairs and literals, with some raw noise bytes.
  task automatic queue_stream(input int unsigned n);
    int unsigned k;
    int unsigned pick;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        pending_bytes.push_back(8'(pcxrle_pkg::RUN_MARK | $urandom_range(0, 63)));
        pending_bytes.push_back(8'($urandom_range(0, 255)));
        k += 2;
      end else if (pick < 8) begin
        pending_bytes.push_back(8'($urandom_range(0, 8'hbf)));
        k++;
      end else begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
        k++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(data_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pending_bytes.size() > 0) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= pending_bytes.pop_front();
          if (idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %h at address %h", $time, pixel_byte_o,
                   dest_address_o);
          mismatches++;
        end else begin
          head_px = expected_pixels.pop_front();
          pixels_checked++;
          if (head_px.pixel !== pixel_byte_o) begin
            $display("%0t: pixel_byte expected %h, got %h", $time, head_px.pixel,
                     pixel_byte_o);
            mismatches++;
          end
          if (head_px.addr !== dest_address_o) begin
            $display("%0t: dest_address expected %h, got %h", $time, head_px.addr,
                     dest_address_o);
            mismatches++;
          end
          if (head_px.run_end !== run_end_o) begin
            $display("%0t: run_end expected %b, got %b", $time, head_px.run_end, run_end_o);
            mismatches++;
          end
          if (head_px.image_done !== image_done_o) begin
            $display("%0t: image_done expected %b, got %b", $time, head_px.image_done,
                     image_done_o);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  initial begin : stimulus
    int unsigned mode_v, line_v, pad_v, planes_v, rows_v, bound;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Literal extremes, zero run, run of a marker-like value, longest run.
    configure(pcxrle_pkg::LAYOUT_MONO, 3, 2, 4, ROW_LIMIT);
    pending_bytes = '{8'h00, 8'h3f, 8'h40, 8'h7f, 8'h80, 8'hbf, 8'hc0, 8'h55,
                      8'hc1, 8'hc0, 8'hc5, 8'hff, 8'hff, 8'h00};
    drain();

    // Out-of-range line and row counts with the widest pad.
    configure(pcxrle_pkg::LAYOUT_PLANAR, 0, 255, 4, 8191);
    pending_bytes = '{8'hff, 8'ha5, 8'h01, 8'hc3, 8'h5a};
    drain();

    // Unused layout code, widest line, plane count above the limit.
    configure(3, 8191, 0, 7, ROW_LIMIT);
    pending_bytes = '{8'h7e, 8'hc4, 8'h81, 8'hff, 8'h3c};
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode_v = p % 3;
      case ($urandom_range(0, 9))
        0:       line_v = 0;
        1:       line_v = LINE_LIMIT;
        2:       line_v = $urandom_range(LINE_LIMIT + 1, 8191);
        default: line_v = $urandom_range(1, 12);
      endcase
      pad_v    = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 3);
      planes_v = $urandom_range(0, 7);
      // Keep the image open: rows must outlast the worst-case advance of this phase.
      bound = (PHASE_BYTES / 2 + 1) * 63 /
              ((clip(line_v, 1, LINE_LIMIT) + pad_v) *
               ((mode_v == pcxrle_pkg::LAYOUT_MONO) ? 1 :
                clip(planes_v, 1, pcxrle_pkg::MAX_PLANES))) + 2;
      if (row_idx + bound + 40 > ROW_LIMIT) begin
        line_v = 64;
        bound  = 20;
      end
      rows_v = row_idx + bound + $urandom_range(1, 40);
      configure(mode_v, line_v, pad_v, planes_v, rows_v);
      idle_on = ($urandom_range(0, 3) != 0);
      queue_stream(PHASE_BYTES);
      drain();
    end

    // Shrink the height below the current row so the image ends at this row,
    // then keep sending bytes that must be dropped.
    configure(pcxrle_pkg::LAYOUT_INTERLEAVED, 3, 1, 2, 0);
    idle_on = 1'b0;
    pending_bytes = '{8'hff, 8'h5a, 8'hff, 8'h5a, 8'hff, 8'h5a, 8'h01, 8'hc1, 8'h02};
    drain();

    $display("Took %0d compressed bytes and checked %0d pixels across mono, planar and",
             bytes_taken, pixels_checked);
    $display("interleaved layouts, zero runs, pad skipping and clamped registers; end=%0d",
             img_finished);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pcxrle_pkg.sv
rtl/pcxrle_ctrl.sv
rtl/pcxrle_dpath.sv
rtl/pcx_rle_plane_decoder.sv
tb/pcx_rle_plane_decoder_tb.sv
